>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on a given clock, ignored while the reset is asserted
`define CGM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define CGM_ASSERT(lbl, prop, msg) \
  `CGM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/cgm_pkg.sv
package cgm_pkg;

  localparam int unsigned GAIN_W      = 8;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 8'd128;
  localparam int unsigned QUOT_BITS   = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [2:0] PART_FULL    = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PART    = 3'd0,
    REG_TYPE    = 3'd1,
    REG_END     = 3'd2,
    REG_OUT_LEN = 3'd3,
    REG_IN_LEN  = 3'd4
  } cfg_reg_e;

  // how a gain is obtained for a header
  typedef enum logic [1:0] {
    GSEL_ZERO,
    GSEL_UNITY,
    GSEL_DIV
  } gsel_e;

  typedef struct packed {
    logic  is_hdr;
    logic  fade_in;
    gsel_e out_sel;
    gsel_e in_sel;
  } item_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV_OUT,
    ST_DIV_IN,
    ST_FIN
  } back_state_e;

endpackage

>>> rtl/crossfade_gain_mixer_top.sv
// sample request: multiplied into product registers, summed into the result register
// header request: 7-step shared restoring divider, run for the fade-out gain and then
// the fade-in gain, each only when needed; the back pops a request only when idle
// a 2-entry queue sits between the front and the back, the result register holds one
// reset (async, active low) clears config registers, both gains, queue and result valid
`include "assert_macros.svh"

module crossfade_gain_mixer_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_BITS  = 32,
  parameter int LEN_BITS    = 24,
  localparam int CfgW = (FRAME_BITS > LEN_BITS) ? FRAME_BITS : LEN_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]                 cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_b_i,
  input  logic [FRAME_BITS-1:0]           frame_a_i,
  input  logic [FRAME_BITS-1:0]           frame_b_i,
  input  logic [FRAME_BITS-1:0]           index_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   mixed_sample_o,
  output logic [cgm_pkg::GAIN_W-1:0]      gain_first_o,
  output logic [cgm_pkg::GAIN_W-1:0]      gain_second_o
);

  import cgm_pkg::*;

  localparam int QW = $bits(item_ctl_t) + 2 * LEN_BITS + 2 * SAMPLE_BITS;

  item_ctl_t                    f_ctl, b_ctl;
  logic [LEN_BITS-1:0]          f_num_out, f_num_in, b_num_out, b_num_in;
  logic signed [SAMPLE_BITS-1:0] f_samp_a, f_samp_x, b_samp_a, b_samp_x;
  logic [LEN_BITS-1:0]          out_len, in_len;
  logic                         q_push, q_pop, q_full, q_valid;
  logic [QW-1:0]                q_wdata, q_rdata;

  cgm_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .sample_a_i   (sample_a_i),
    .sample_b_i   (sample_b_i),
    .frame_a_i    (frame_a_i),
    .frame_b_i    (frame_b_i),
    .index_start_i(index_start_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .ctl_o        (f_ctl),
    .num_out_o    (f_num_out),
    .num_in_o     (f_num_in),
    .samp_a_o     (f_samp_a),
    .samp_x_o     (f_samp_x),
    .out_len_o    (out_len),
    .in_len_o     (in_len)
  );

  assign q_wdata = {f_ctl, f_num_out, f_num_in, f_samp_a, f_samp_x};
  assign {b_ctl, b_num_out, b_num_in, b_samp_a, b_samp_x} = q_rdata;

  cgm_fifo #(
    .DATA_W(QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  cgm_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .pop_o         (q_pop),
    .ctl_i         (b_ctl),
    .num_out_i     (b_num_out),
    .num_in_i      (b_num_in),
    .samp_a_i      (b_samp_a),
    .samp_x_i      (b_samp_x),
    .out_len_i     (out_len),
    .in_len_i      (in_len),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mixed_sample_o(mixed_sample_o),
    .gain_first_o  (gain_first_o),
    .gain_second_o (gain_second_o)
  );

  `CGM_ASSERT(a_gain_range, out_valid_o |-> (gain_first_o <= GAIN_UNITY && gain_second_o <= GAIN_UNITY), "gain above unity")
  `CGM_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
  `CGM_ASSERT(a_queue_kept, (q_valid && !q_pop) |=> q_valid, "queued request lost")

endmodule

>>> rtl/cgm_fifo.sv
module cgm_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/cgm_front.sv
module cgm_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_BITS  = 32,
  parameter int LEN_BITS    = 24,
  localparam int CfgW = (FRAME_BITS > LEN_BITS) ? FRAME_BITS : LEN_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]                 cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_b_i,
  input  logic [FRAME_BITS-1:0]           frame_a_i,
  input  logic [FRAME_BITS-1:0]           frame_b_i,
  input  logic [FRAME_BITS-1:0]           index_start_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output cgm_pkg::item_ctl_t              ctl_o,
  output logic [LEN_BITS-1:0]             num_out_o,
  output logic [LEN_BITS-1:0]             num_in_o,
  output logic signed [SAMPLE_BITS-1:0]   samp_a_o,
  output logic signed [SAMPLE_BITS-1:0]   samp_x_o,
  output logic [LEN_BITS-1:0]             out_len_o,
  output logic [LEN_BITS-1:0]             in_len_o
);

  import cgm_pkg::*;

  logic [2:0]            part_q;
  logic [1:0]            type_q;
  logic [FRAME_BITS-1:0] end_q;
  logic [LEN_BITS-1:0]   out_len_q, in_len_q;

  logic [FRAME_BITS-1:0] fr, span, pos;
  logic [CfgW-1:0]       span_ext, pos_ext, out_len_ext, in_len_ext;
  logic                  past_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q    <= '0;
      type_q    <= '0;
      end_q     <= '0;
      out_len_q <= '0;
      in_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PART:    part_q    <= cfg_wdata_i[2:0];
        REG_TYPE:    type_q    <= cfg_wdata_i[1:0];
        REG_END:     end_q     <= cfg_wdata_i[FRAME_BITS-1:0];
        REG_OUT_LEN: out_len_q <= cfg_wdata_i[LEN_BITS-1:0];
        REG_IN_LEN:  in_len_q  <= cfg_wdata_i[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign out_len_o  = out_len_q;
  assign in_len_o   = in_len_q;

  always_comb begin
    fr          = part_q[2] ? frame_b_i : frame_a_i;
    past_end    = (end_q <= fr);
    span        = end_q - fr;
    pos         = frame_a_i - index_start_i;
    span_ext    = CfgW'(span);
    pos_ext     = CfgW'(pos);
    out_len_ext = CfgW'(out_len_q);
    in_len_ext  = CfgW'(in_len_q);

    ctl_o.is_hdr  = !func_i;
    ctl_o.fade_in = part_q[1];
    // distance at or beyond the length saturates at unity, a zero length included
    if (!part_q[0] || past_end) begin
      ctl_o.out_sel = GSEL_ZERO;
    end else if (!type_q[0] || (span_ext >= out_len_ext)) begin
      ctl_o.out_sel = GSEL_UNITY;
    end else begin
      ctl_o.out_sel = GSEL_DIV;
    end
    ctl_o.in_sel = (type_q[1] && (pos_ext < in_len_ext)) ? GSEL_DIV : GSEL_UNITY;

    num_out_o = span_ext[LEN_BITS-1:0];
    num_in_o  = pos_ext[LEN_BITS-1:0];
    samp_a_o  = sample_a_i;
    samp_x_o  = (part_q == PART_FULL) ? sample_b_i : sample_a_i;
  end

endmodule

>>> rtl/cgm_back.sv
module cgm_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int LEN_BITS    = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  output logic                                pop_o,
  input  cgm_pkg::item_ctl_t                  ctl_i,
  input  logic [LEN_BITS-1:0]                 num_out_i,
  input  logic [LEN_BITS-1:0]                 num_in_i,
  input  logic signed [SAMPLE_BITS-1:0]       samp_a_i,
  input  logic signed [SAMPLE_BITS-1:0]       samp_x_i,
  input  logic [LEN_BITS-1:0]                 out_len_i,
  input  logic [LEN_BITS-1:0]                 in_len_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       mixed_sample_o,
  output logic [cgm_pkg::GAIN_W-1:0]          gain_first_o,
  output logic [cgm_pkg::GAIN_W-1:0]          gain_second_o
);

  import cgm_pkg::*;

  localparam int PW   = SAMPLE_BITS + GAIN_W + 1;
  localparam int TW   = PW - 7;
  localparam int SW   = TW + 1;
  localparam int CntW = $clog2(QUOT_BITS);
  localparam logic signed [SW-1:0] MaxV =
    {{(SW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] MinV = ~MaxV;

  back_state_e state_q, state_d;
  item_ctl_t   ctl_q, ctl_d;

  logic [LEN_BITS-1:0]    rem_q, rem_d, num_in_q, num_in_d;
  logic [QUOT_BITS-1:0]   quo_q, quo_d, quo_next;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [GAIN_W-1:0]      g_out_q, g_out_d, g_in_q, g_in_d;
  logic [GAIN_W-1:0]      gain_one_q, gain_one_d, gain_two_q, gain_two_d;
  logic signed [PW-1:0]   prod1_q, prod1_d, prod2_q, prod2_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_mix_q, out_mix_d, sat;
  logic [GAIN_W-1:0]      out_g1_q, out_g1_d, out_g2_q, out_g2_d;

  logic                  out_free, div_last, step_ge, want_in;
  logic [LEN_BITS-1:0]   divisor, rem_next;
  logic [LEN_BITS:0]     rem_dbl;
  logic signed [TW-1:0]  t1, t2;
  logic signed [SW-1:0]  sum;

  assign out_free       = !out_valid_q || out_ready_i;
  assign pop_o          = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_mix_q;
  assign gain_first_o   = out_g1_q;
  assign gain_second_o  = out_g2_q;

  // one restoring step of the shared divider, remainder stays below the divisor
  always_comb begin
    divisor  = (state_q == ST_DIV_IN) ? in_len_i : out_len_i;
    rem_dbl  = {rem_q, 1'b0};
    step_ge  = (rem_dbl >= {1'b0, divisor});
    rem_next = step_ge ? LEN_BITS'(rem_dbl - {1'b0, divisor}) : rem_dbl[LEN_BITS-1:0];
    quo_next = {quo_q[QUOT_BITS-2:0], step_ge};
    div_last = (cnt_q == CntW'(QUOT_BITS - 1));
    want_in  = ctl_q.fade_in && (ctl_q.in_sel == GSEL_DIV);
  end

  // truncate toward zero, add and clamp
  always_comb begin
    t1  = TW'(prod1_q >>> 7) + TW'(prod1_q[PW-1] && (|prod1_q[6:0]));
    t2  = TW'(prod2_q >>> 7) + TW'(prod2_q[PW-1] && (|prod2_q[6:0]));
    sum = SW'(t1) + SW'(t2);
    priority if (sum > MaxV) begin
      sat = MaxV[SAMPLE_BITS-1:0];
    end else if (sum < MinV) begin
      sat = MinV[SAMPLE_BITS-1:0];
    end else begin
      sat = sum[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          priority if (!ctl_i.is_hdr) begin
            state_d = ST_MIX;
          end else if (ctl_i.out_sel == GSEL_DIV) begin
            state_d = ST_DIV_OUT;
          end else if (ctl_i.fade_in && (ctl_i.in_sel == GSEL_DIV)) begin
            state_d = ST_DIV_IN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MIX: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DIV_OUT: begin
        if (div_last) state_d = want_in ? ST_DIV_IN : ST_FIN;
      end
      ST_DIV_IN: begin
        if (div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_d       = ctl_q;
    rem_d       = rem_q;
    num_in_d    = num_in_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    g_out_d     = g_out_q;
    g_in_d      = g_in_q;
    gain_one_d  = gain_one_q;
    gain_two_d  = gain_two_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_mix_d   = out_mix_q;
    out_g1_d    = out_g1_q;
    out_g2_d    = out_g2_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          ctl_d    = ctl_i;
          num_in_d = num_in_i;
          rem_d    = (ctl_i.out_sel == GSEL_DIV) ? num_out_i : num_in_i;
          quo_d    = '0;
          cnt_d    = '0;
          g_out_d  = (ctl_i.out_sel == GSEL_UNITY) ? GAIN_UNITY : '0;
          g_in_d   = GAIN_UNITY;
          prod1_d  = PW'(samp_a_i) * PW'($signed({1'b0, gain_one_q}));
          prod2_d  = PW'(samp_x_i) * PW'($signed({1'b0, gain_two_q}));
        end
      end
      ST_MIX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mix_d   = sat;
          out_g1_d    = gain_one_q;
          out_g2_d    = gain_two_q;
        end
      end
      ST_DIV_OUT: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          g_out_d = {1'b0, quo_next};
          rem_d   = num_in_q;
          quo_d   = '0;
          cnt_d   = '0;
        end
      end
      ST_DIV_IN: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          g_in_d = {1'b0, quo_next};
        end
      end
      ST_FIN: begin
        if (out_free) begin
          gain_one_d  = ctl_q.fade_in ? g_in_q : g_out_q;
          gain_two_d  = ctl_q.fade_in ? g_out_q : '0;
          out_valid_d = 1'b1;
          out_mix_d   = '0;
          out_g1_d    = ctl_q.fade_in ? g_in_q : g_out_q;
          out_g2_d    = ctl_q.fade_in ? g_out_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      gain_one_q  <= '0;
      gain_two_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gain_one_q  <= gain_one_d;
      gain_two_q  <= gain_two_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q    <= ctl_d;
    rem_q    <= rem_d;
    num_in_q <= num_in_d;
    quo_q    <= quo_d;
    g_out_q  <= g_out_d;
    g_in_q   <= g_in_d;
    prod1_q  <= prod1_d;
    prod2_q  <= prod2_d;
    out_mix_q <= out_mix_d;
    out_g1_q <= out_g1_d;
    out_g2_q <= out_g2_d;
  end

endmodule
